FILE: sv/tftp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP session sequencer package
// Shared types and constants for the front and back parts of the sequencer.
// ----------------------------------------------------------------------------
package tftp_pkg;

	localparam logic [1:0] FUNC_REQ  = 2'd0;
	localparam logic [1:0] FUNC_PKT  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [15:0] OP_RRQ  = 16'd1;
	localparam logic [15:0] OP_WRQ  = 16'd2;
	localparam logic [15:0] OP_DATA = 16'd3;
	localparam logic [15:0] OP_ACK  = 16'd4;

	localparam logic [1:0] K_NONE = 2'd0;
	localparam logic [1:0] K_DATA = 2'd1;
	localparam logic [1:0] K_ACK  = 2'd2;
	localparam logic [1:0] K_ERR  = 2'd3;

	localparam logic [2:0] E_BUSY      = 3'd0;
	localparam logic [2:0] E_NOT_FOUND = 3'd1;
	localparam logic [2:0] E_ACCESS    = 3'd2;
	localparam logic [2:0] E_MALFORMED = 3'd3;
	localparam logic [2:0] E_BAD_MODE  = 3'd4;
	localparam logic [2:0] E_TID       = 3'd5;

	localparam logic [9:0] BLKSZ = 10'd512;
	localparam int MAXRES = 16;

	localparam logic [0:0] CFG_TIMEOUT = 1'd0;
	localparam logic [0:0] CFG_RETRIES = 1'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot;
		logic [15:0] opcode;
		logic [15:0] block;
		logic [9:0]  payload_len;
		logic        sender_matches;
		logic        request_well_formed;
		logic        mode_is_octet;
		logic        lock_granted;
		logic        file_opened;
		logic [9:0]  read_len;
	} item_t;

	typedef struct packed {
		logic [3:0]  out_slot;
		logic [1:0]  send_kind;
		logic [15:0] send_block;
		logic [9:0]  data_len;
		logic [2:0]  error_kind;
		logic        session_opened;
		logic        session_closed;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_WAIT
	} back_state_t;

	function automatic logic [9:0] clamp_len(input logic [9:0] v);
		clamp_len = (v > BLKSZ) ? BLKSZ : v;
	endfunction

endpackage

FILE: sv/tftp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP front queue
// Accepts event beats, drops events that cannot cause work and queues the rest.
// ----------------------------------------------------------------------------
module tftp_front
	import tftp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t in_item,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_take
);

	item_t       mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        keep;
	logic        wr;

	assign full = (cnt_q == 2'd2);
	assign keep = (in_item.func == FUNC_TICK) || (in_item.func == FUNC_PKT) ||
		((in_item.func == FUNC_REQ) &&
		 ((in_item.opcode == OP_RRQ) || (in_item.opcode == OP_WRQ)));
	assign wr = push && !full && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (q_take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, q_take};
		end
	end

endmodule

FILE: sv/tftp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP back end
// Holds the slot table and turns each queued event into result beats.
// ----------------------------------------------------------------------------
module tftp_back
	import tftp_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] timeout_ticks,
	input  logic [3:0] retry_limit,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_take,
	output logic       res_valid,
	output result_t    res,
	input  logic       res_pop
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] active_q;
	logic             is_write_q  [SLOTS];
	logic [15:0]      blk_q       [SLOTS];
	logic [9:0]       ldl_q       [SLOTS];
	logic             wfo_q       [SLOTS];
	logic [4:0]       retry_q     [SLOTS];
	logic [7:0]       idle_q      [SLOTS];

	back_state_t st_q, st_d;
	logic [SW-1:0] ti_q;
	logic [4:0]    tn_q;
	result_t       out_q;
	logic          ov_q;
	result_t       pend_q;
	logic          pv_q;

	logic          free_found;
	logic [SW-1:0] free_idx;
	logic [SW-1:0] ps;
	logic          slot_ok;
	logic          do_emit;
	result_t       em;
	logic          tick_last_slot;
	logic          tick_hit;
	logic          tick_inc;
	logic [4:0]    tick_retry;
	logic          out_free;
	logic          tick_go;
	logic          rel;
	result_t       rel_beat;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	assign ps = SW'(q_item.slot);
	assign slot_ok = (int'(q_item.slot) < SLOTS) && active_q[ps];
	assign tick_last_slot = (ti_q == SW'(SLOTS - 1));
	assign tick_inc = (idle_q[ti_q] < 8'd255) &&
		({1'b0, idle_q[ti_q]} + 9'd1 < {1'b0, timeout_ticks});
	assign tick_hit = active_q[ti_q] && !tick_inc;
	assign tick_retry = retry_q[ti_q] + 5'd1;

	// output stage: a pending beat moves to the register when it frees
	assign res_valid = ov_q;
	assign res = out_q;
	assign q_take = (st_q == ST_IDLE) && q_valid && !pv_q;
	assign out_free = !ov_q || res_pop;
	assign tick_go = (st_q == ST_TICK) && (!pv_q || out_free);
	// during a tick the held beat leaves only when a newer beat replaces it
	assign rel = pv_q && out_free && ((st_q != ST_TICK) || do_emit);

	always_comb begin
		rel_beat = pend_q;
		rel_beat.last = pend_q.last || (st_q == ST_WAIT);
	end

	always_comb begin
		st_d = st_q;
		do_emit = 1'b0;
		em = '0;
		case (st_q)
			ST_IDLE: begin
				if (q_take) begin
					em.last = 1'b1;
					case (q_item.func)
						FUNC_REQ: begin
							if (!q_item.request_well_formed) begin
								do_emit = 1'b1;
								em.send_kind = K_ERR;
								em.error_kind = E_MALFORMED;
							end else if (!q_item.mode_is_octet) begin
								do_emit = 1'b1;
								em.send_kind = K_ERR;
								em.error_kind = E_BAD_MODE;
							end else if (free_found) begin
								do_emit = 1'b1;
								em.out_slot = 4'(free_idx);
								if (!q_item.lock_granted) begin
									em.send_kind = K_ERR;
									em.error_kind = E_BUSY;
								end else if (q_item.opcode == OP_RRQ) begin
									em.session_opened = 1'b1;
									if (!q_item.file_opened) begin
										em.send_kind = K_ERR;
										em.error_kind = E_NOT_FOUND;
										em.session_closed = 1'b1;
									end else begin
										em.send_kind = K_DATA;
										em.send_block = 16'd1;
										em.data_len = clamp_len(q_item.read_len);
									end
								end else begin
									em.session_opened = 1'b1;
									em.send_kind = K_ACK;
								end
							end
						end
						FUNC_PKT: begin
							em.out_slot = q_item.slot;
							if (slot_ok) begin
								if (!q_item.sender_matches) begin
									do_emit = 1'b1;
									em.send_kind = K_ERR;
									em.error_kind = E_TID;
								end else if (!is_write_q[ps]) begin
									if (q_item.opcode == OP_ACK &&
									    q_item.block == blk_q[ps]) begin
										do_emit = 1'b1;
										if (ldl_q[ps] < BLKSZ) begin
											em.session_closed = 1'b1;
										end else begin
											em.send_kind = K_DATA;
											em.send_block = blk_q[ps] + 16'd1;
											em.data_len = clamp_len(q_item.read_len);
										end
									end
								end else if (q_item.opcode == OP_DATA) begin
									if (q_item.block == blk_q[ps] + 16'd1) begin
										do_emit = 1'b1;
										if (!wfo_q[ps] && !q_item.file_opened) begin
											em.send_kind = K_ERR;
											em.error_kind = E_ACCESS;
											em.session_closed = 1'b1;
										end else begin
											em.send_kind = K_ACK;
											em.send_block = q_item.block;
											em.session_closed =
												clamp_len(q_item.payload_len) < BLKSZ;
										end
									end else if (q_item.block == blk_q[ps]) begin
										do_emit = 1'b1;
										em.send_kind = K_ACK;
										em.send_block = blk_q[ps];
									end
								end
							end
						end
						FUNC_TICK: begin
							st_d = ST_TICK;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TICK: begin
				if (tick_go) begin
					em.out_slot = 4'(ti_q);
					if (tick_hit && tn_q < 5'(MAXRES)) begin
						do_emit = 1'b1;
						if (tick_retry > {1'b0, retry_limit}) begin
							em.session_closed = 1'b1;
						end else if (is_write_q[ti_q]) begin
							em.send_kind = K_ACK;
							em.send_block = blk_q[ti_q];
						end else begin
							em.send_kind = K_DATA;
							em.send_block = blk_q[ti_q];
							em.data_len = ldl_q[ti_q];
						end
					end
					if (tick_last_slot || (tick_hit && tn_q >= 5'(MAXRES))) begin
						st_d = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				if (!pv_q || out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			active_q <= '0;
			ti_q     <= '0;
			tn_q     <= '0;
			ov_q     <= 1'b0;
			pv_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (rel) begin
				ov_q <= 1'b1;
			end else if (res_pop) begin
				ov_q <= 1'b0;
			end
			if (do_emit) begin
				pv_q <= 1'b1;
			end else if (rel) begin
				pv_q <= 1'b0;
			end
			if (q_take && q_item.func == FUNC_TICK) begin
				ti_q <= '0;
				tn_q <= '0;
			end else if (tick_go) begin
				ti_q <= ti_q + SW'(1);
				if (do_emit) begin
					tn_q <= tn_q + 5'd1;
				end
			end
			if (q_take && q_item.func == FUNC_REQ && q_item.request_well_formed &&
			    q_item.mode_is_octet && free_found && q_item.lock_granted &&
			    (q_item.opcode == OP_WRQ || q_item.file_opened)) begin
				active_q[free_idx] <= 1'b1;
			end
			if (q_take && q_item.func == FUNC_PKT && do_emit && em.session_closed) begin
				active_q[ps] <= 1'b0;
			end
			if (st_q == ST_TICK && do_emit && em.session_closed) begin
				active_q[ti_q] <= 1'b0;
			end
		end
	end

	// tick beats: each new beat is held in pend; the previous one is released as
	// not-last. The held beat is marked last when the scan ends.
	always_ff @(posedge clk) begin
		if (do_emit) begin
			pend_q <= em;
		end
		if (rel) begin
			out_q <= rel_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take && q_item.func == FUNC_REQ && q_item.request_well_formed &&
		    q_item.mode_is_octet && free_found && q_item.lock_granted) begin
			retry_q[free_idx] <= '0;
			idle_q[free_idx]  <= '0;
			is_write_q[free_idx] <= (q_item.opcode == OP_WRQ);
			blk_q[free_idx] <= (q_item.opcode == OP_RRQ) ? 16'd1 : 16'd0;
			ldl_q[free_idx] <= clamp_len(q_item.read_len);
			wfo_q[free_idx] <= 1'b0;
		end
		if (q_take && q_item.func == FUNC_PKT && slot_ok && q_item.sender_matches) begin
			idle_q[ps]  <= '0;
			retry_q[ps] <= '0;
			if (do_emit && !em.session_closed && em.send_kind == K_DATA) begin
				blk_q[ps] <= em.send_block;
				ldl_q[ps] <= em.data_len;
			end
			if (do_emit && is_write_q[ps] && em.send_kind == K_ACK &&
			    q_item.block == blk_q[ps] + 16'd1) begin
				blk_q[ps] <= q_item.block;
				wfo_q[ps] <= 1'b1;
			end
		end
		if (tick_go && active_q[ti_q]) begin
			if (tick_inc) begin
				idle_q[ti_q] <= idle_q[ti_q] + 8'd1;
			end else if (do_emit) begin
				retry_q[ti_q] <= tick_retry;
				idle_q[ti_q]  <= '0;
			end
		end
	end

endmodule

FILE: sv/tftp_session_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP session sequencer
// Slot table controller for TFTP server transfers, one event per beat.
// ----------------------------------------------------------------------------
// Input channel: push/full, one event beat (request, packet or tick).
// Result channel: empty/pop, zero or more result beats per event, last marks
// the final beat of an event; events giving no result produce no beat.
// A two-entry queue sits between the front and the back end.
// A request or packet result is registered in the pending and output stages;
// the back end takes no new event while a result beat is still pending.
// A tick walks the slot table one slot a cycle unless the receiver stalls,
// then passes through a wait state before the next event is taken.
// Each tick beat is held one step so it can be marked last; a stalled
// receiver holds the back end and then fills the queue, raising full.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once; the
// user must make them only while idle, as the block does not enforce this.
// Reset clears all slots to free and restores timeout 5 and retries 5.
// ----------------------------------------------------------------------------
module tftp_session_sequencer_unit
	import tftp_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [3:0]  slot,
	input  logic [15:0] opcode,
	input  logic [15:0] block,
	input  logic [9:0]  payload_len,
	input  logic        sender_matches,
	input  logic        request_well_formed,
	input  logic        mode_is_octet,
	input  logic        lock_granted,
	input  logic        file_opened,
	input  logic [9:0]  read_len,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  out_slot,
	output logic [1:0]  send_kind,
	output logic [15:0] send_block,
	output logic [9:0]  data_len,
	output logic [2:0]  error_kind,
	output logic        session_opened,
	output logic        session_closed,
	output logic        last
);

	logic [7:0] timeout_q;
	logic [3:0] retries_q;
	item_t      in_item, q_item;
	logic       q_valid, q_take, res_valid;
	result_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 8'd5;
			retries_q <= 4'd5;
		end else if (wr_en) begin
			if (wr_index == CFG_TIMEOUT) begin
				timeout_q <= wr_data;
			end else begin
				retries_q <= wr_data[3:0];
			end
		end
	end

	always_comb begin
		in_item.func = func;
		in_item.slot = slot;
		in_item.opcode = opcode;
		in_item.block = block;
		in_item.payload_len = payload_len;
		in_item.sender_matches = sender_matches;
		in_item.request_well_formed = request_well_formed;
		in_item.mode_is_octet = mode_is_octet;
		in_item.lock_granted = lock_granted;
		in_item.file_opened = file_opened;
		in_item.read_len = read_len;
	end

	tftp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	tftp_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .timeout_ticks(timeout_q),
		.retry_limit(retries_q), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take), .res_valid(res_valid), .res(res), .res_pop(pop)
	);

	assign empty = !res_valid;
	assign out_slot = res.out_slot;
	assign send_kind = res.send_kind;
	assign send_block = res.send_block;
	assign data_len = res.data_len;
	assign error_kind = res.error_kind;
	assign session_opened = res.session_opened;
	assign session_closed = res.session_closed;
	assign last = res.last;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP session sequencer testbench
// Drives request, packet and tick events into the slot table controller.
// A cycle-free model of the slot table predicts each result beat, and every
// popped beat is compared field by field. The run starts with a directed
// table, fills the table and stalls the result side, then sends random
// traffic under several timeout and retry settings.
// ----------------------------------------------------------------------------
module testbench;
	import tftp_pkg::*;

	localparam int NSLOT = 16;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [0:0]  wr_index = '0;
	logic [7:0]  wr_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic        empty;
	logic        pop = 1'b0;
	item_t       drv = '0;
	result_t     got;

	// slot table copy and register copy
	bit          act[NSLOT];
	bit          is_wr[NSLOT];
	logic [15:0] blkno[NSLOT];
	logic [9:0]  lastlen[NSLOT];
	bit          wopen[NSLOT];
	logic [4:0]  retries[NSLOT];
	logic [7:0]  idle[NSLOT];
	logic [7:0]  cfg_timeout = 8'd5;
	logic [3:0]  cfg_retries = 4'd5;

	result_t     pending_beats[$];
	int          errors = 0;
	int          n_items = 0;
	int          n_beats = 0;
	int          n_ticks = 0;
	bit          no_idle = 1'b0;
	bit          hold_req = 1'b0;
	bit          saw_full = 1'b0;

	always #5 clk = ~clk;

	tftp_session_sequencer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.push(push), .full(full),
		.func(drv.func), .slot(drv.slot), .opcode(drv.opcode), .block(drv.block),
		.payload_len(drv.payload_len), .sender_matches(drv.sender_matches),
		.request_well_formed(drv.request_well_formed),
		.mode_is_octet(drv.mode_is_octet), .lock_granted(drv.lock_granted),
		.file_opened(drv.file_opened), .read_len(drv.read_len),
		.empty(empty), .pop(pop),
		.out_slot(got.out_slot), .send_kind(got.send_kind),
		.send_block(got.send_block), .data_len(got.data_len),
		.error_kind(got.error_kind), .session_opened(got.session_opened),
		.session_closed(got.session_closed), .last(got.last)
	);

	function automatic logic [9:0] sat512(input logic [9:0] v);
		return (v > 10'd512) ? 10'd512 : v;
	endfunction

	function automatic result_t beat(input int s, input logic [1:0] kind,
		input logic [15:0] b, input logic [9:0] len, input logic [2:0] err,
		input bit op, input bit cl);
		result_t r;
		r.out_slot = s[3:0];
		r.send_kind = kind;
		r.send_block = b;
		r.data_len = len;
		r.error_kind = err;
		r.session_opened = op;
		r.session_closed = cl;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic item_t itm(input logic [1:0] f, input int s,
		input logic [15:0] op, input logic [15:0] b, input logic [9:0] plen,
		input bit snd, input bit wf, input bit oct, input bit lk, input bit fo,
		input logic [9:0] rl);
		item_t it;
		it.func = f;
		it.slot = s[3:0];
		it.opcode = op;
		it.block = b;
		it.payload_len = plen;
		it.sender_matches = snd;
		it.request_well_formed = wf;
		it.mode_is_octet = oct;
		it.lock_granted = lk;
		it.file_opened = fo;
		it.read_len = rl;
		return it;
	endfunction

	// advance the slot table by one event, appending its result beats
	function automatic void session_step(input item_t it, ref result_t q[$]);
		int f;
		int s;
		int n;
		logic [15:0] cur;
		bit cl;
		n = 0;
		f = -1;
		s = it.slot;
		case (it.func)
			FUNC_REQ: begin
				if (it.opcode != OP_RRQ && it.opcode != OP_WRQ)
					return;
				if (!it.request_well_formed) begin
					q.push_back(beat(0, K_ERR, 0, 0, E_MALFORMED, 0, 0));
					return;
				end
				if (!it.mode_is_octet) begin
					q.push_back(beat(0, K_ERR, 0, 0, E_BAD_MODE, 0, 0));
					return;
				end
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!act[i])
						f = i;
				if (f < 0)
					return;
				if (!it.lock_granted) begin
					q.push_back(beat(f, K_ERR, 0, 0, E_BUSY, 0, 0));
					return;
				end
				retries[f] = 0;
				idle[f] = 0;
				if (it.opcode == OP_RRQ) begin
					if (!it.file_opened) begin
						q.push_back(beat(f, K_ERR, 0, 0, E_NOT_FOUND, 1, 1));
						return;
					end
					act[f] = 1;
					is_wr[f] = 0;
					blkno[f] = 16'd1;
					lastlen[f] = sat512(it.read_len);
					q.push_back(beat(f, K_DATA, 16'd1, lastlen[f], 0, 1, 0));
				end else begin
					act[f] = 1;
					is_wr[f] = 1;
					blkno[f] = 16'd0;
					wopen[f] = 0;
					q.push_back(beat(f, K_ACK, 0, 0, 0, 1, 0));
				end
			end
			FUNC_PKT: begin
				if (!act[s])
					return;
				if (!it.sender_matches) begin
					q.push_back(beat(s, K_ERR, 0, 0, E_TID, 0, 0));
					return;
				end
				idle[s] = 0;
				retries[s] = 0;
				cur = blkno[s];
				if (!is_wr[s]) begin
					if (it.opcode != OP_ACK || it.block != cur)
						return;
					if (lastlen[s] < BLKSZ) begin
						act[s] = 0;
						q.push_back(beat(s, K_NONE, 0, 0, 0, 0, 1));
						return;
					end
					blkno[s] = cur + 16'd1;
					lastlen[s] = sat512(it.read_len);
					q.push_back(beat(s, K_DATA, blkno[s], lastlen[s], 0, 0, 0));
					return;
				end
				if (it.opcode != OP_DATA)
					return;
				if (it.block == cur + 16'd1) begin
					if (!wopen[s]) begin
						if (!it.file_opened) begin
							act[s] = 0;
							q.push_back(beat(s, K_ERR, 0, 0, E_ACCESS, 0, 1));
							return;
						end
						wopen[s] = 1;
					end
					blkno[s] = it.block;
					cl = sat512(it.payload_len) < BLKSZ;
					if (cl)
						act[s] = 0;
					q.push_back(beat(s, K_ACK, it.block, 0, 0, 0, cl));
				end else if (it.block == cur) begin
					q.push_back(beat(s, K_ACK, cur, 0, 0, 0, 0));
				end
			end
			FUNC_TICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (!act[i])
						continue;
					if (idle[i] < 8'd255 && int'(idle[i]) + 1 < int'(cfg_timeout)) begin
						idle[i]++;
						continue;
					end
					if (n >= MAXRES)
						break;
					retries[i] = retries[i] + 5'd1;
					if (retries[i] > {1'b0, cfg_retries}) begin
						act[i] = 0;
						q.push_back(beat(i, K_NONE, 0, 0, 0, 0, 1));
					end else if (is_wr[i]) begin
						idle[i] = 0;
						q.push_back(beat(i, K_ACK, blkno[i], 0, 0, 0, 0));
					end else begin
						idle[i] = 0;
						q.push_back(beat(i, K_DATA, blkno[i], lastlen[i], 0, 0, 0));
					end
					n++;
				end
				for (int k = q.size() - n; k < q.size() - 1; k++)
					q[k].last = 1'b0;
			end
			default: ;
		endcase
	endfunction

	task automatic report(input string what);
		errors++;
		$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	task automatic send(input item_t it, input bit typed, input result_t res);
		result_t scratch[$];
		drv <= it;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		n_items++;
		if (it.func == FUNC_TICK)
			n_ticks++;
		if (typed) begin
			session_step(it, scratch);
			pending_beats.push_back(res);
		end else begin
			session_step(it, pending_beats);
		end
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
		drain();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_TIMEOUT)
			cfg_timeout = val;
		else
			cfg_retries = val[3:0];
	endtask

	function automatic logic [9:0] pick_len();
		return ($urandom_range(0, 9) < 7) ? 10'd512 : 10'($urandom_range(0, 1023));
	endfunction

	function automatic item_t random_item();
		int r;
		int s;
		int na;
		int live[$];
		item_t it;
		r = $urandom_range(0, 99);
		for (int i = 0; i < NSLOT; i++)
			if (act[i])
				live.push_back(i);
		na = live.size();
		if (r < 10) begin
			it = itm(2'($urandom_range(0, 3)), $urandom_range(0, 15), 16'($urandom),
				16'($urandom), 10'($urandom_range(0, 1023)), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 1'($urandom), 10'($urandom_range(0, 1023)));
		end else if (r < 35 || (r < 85 && na == 0)) begin
			it = itm(FUNC_REQ, $urandom_range(0, 15),
				$urandom_range(0, 1) ? OP_RRQ : OP_WRQ, 16'($urandom),
				10'($urandom_range(0, 1023)), 1'($urandom), $urandom_range(0, 9) != 0,
				$urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0,
				$urandom_range(0, 7) != 0, pick_len());
		end else if (r < 85) begin
			s = live[$urandom_range(0, na - 1)];
			it = itm(FUNC_PKT, s, OP_ACK, blkno[s], pick_len(),
				$urandom_range(0, 19) != 0, 1'($urandom), 1'($urandom), 1'($urandom),
				$urandom_range(0, 9) != 0, pick_len());
			if (is_wr[s]) begin
				it.opcode = OP_DATA;
				r = $urandom_range(0, 9);
				it.block = (r < 8) ? blkno[s] + 16'd1 : (r < 9) ? blkno[s] : 16'($urandom);
			end else if ($urandom_range(0, 9) == 0) begin
				it.block = 16'($urandom);
			end
		end else begin
			it = itm(FUNC_TICK, $urandom_range(0, 15), 16'($urandom), 16'($urandom), 0, 0,
				0, 0, 0, 0, 0);
		end
		return it;
	endfunction

	// result side
	initial begin
		result_t e;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (full)
				saw_full = 1'b1;
			if (pop && !empty) begin
				n_beats++;
				if (pending_beats.size() == 0) begin
					report($sformatf("unexpected beat slot %0d kind %0d",
						got.out_slot, got.send_kind));
				end else begin
					e = pending_beats.pop_front();
					if (got.out_slot !== e.out_slot)
						report($sformatf("out_slot %0d, want %0d", got.out_slot, e.out_slot));
					if (got.send_kind !== e.send_kind)
						report($sformatf("send_kind %0d, want %0d", got.send_kind, e.send_kind));
					if (got.send_block !== e.send_block)
						report($sformatf("send_block %0d, want %0d", got.send_block,
							e.send_block));
					if (got.data_len !== e.data_len)
						report($sformatf("data_len %0d, want %0d", got.data_len, e.data_len));
					if (got.error_kind !== e.error_kind)
						report($sformatf("error_kind %0d, want %0d", got.error_kind,
							e.error_kind));
					if (got.session_opened !== e.session_opened)
						report("session_opened differs");
					if (got.session_closed !== e.session_closed)
						report("session_closed differs");
					if (got.last !== e.last)
						report("last differs");
				end
			end
		end
	end

	// event side
	initial begin
		row_t rows[$];
		row_t rw;
		item_t none;
		none = '0;
		rw.typed = 1'b0;
		rw.res = '0;
		rw.it = itm(FUNC_REQ, 0, OP_RRQ, 0, 0, 1, 0, 1, 1, 1, 512);
		rows.push_back('{rw.it, 1, beat(0, K_ERR, 0, 0, E_MALFORMED, 0, 0)});
		rw.it = itm(FUNC_REQ, 0, OP_WRQ, 0, 0, 1, 1, 0, 1, 1, 512);
		rows.push_back('{rw.it, 1, beat(0, K_ERR, 0, 0, E_BAD_MODE, 0, 0)});
		rows.push_back('{itm(FUNC_REQ, 15, 16'hFFFF, 16'hFFFF, 1023, 1, 1, 1, 1, 1,
			1023), 0, rw.res});
		rows.push_back('{itm(FUNC_REQ, 0, OP_RRQ, 0, 0, 1, 1, 1, 0, 1, 512), 1,
			beat(0, K_ERR, 0, 0, E_BUSY, 0, 0)});
		rows.push_back('{itm(FUNC_REQ, 0, OP_RRQ, 0, 0, 1, 1, 1, 1, 0, 512), 1,
			beat(0, K_ERR, 0, 0, E_NOT_FOUND, 1, 1)});
		rows.push_back('{itm(FUNC_REQ, 0, OP_RRQ, 0, 0, 1, 1, 1, 1, 1, 1023), 1,
			beat(0, K_DATA, 1, 512, 0, 1, 0)});
		rows.push_back('{itm(FUNC_REQ, 0, OP_WRQ, 0, 0, 1, 1, 1, 1, 1, 0), 1,
			beat(1, K_ACK, 0, 0, 0, 1, 0)});
		rows.push_back('{itm(FUNC_PKT, 0, OP_ACK, 1, 0, 0, 1, 1, 1, 1, 100), 1,
			beat(0, K_ERR, 0, 0, E_TID, 0, 0)});
		rows.push_back('{itm(FUNC_PKT, 0, OP_ACK, 1, 0, 1, 0, 0, 0, 0, 100), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 0, OP_ACK, 7, 0, 1, 0, 0, 0, 0, 100), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 0, OP_ACK, 2, 0, 1, 0, 0, 0, 0, 100), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 9, OP_ACK, 0, 0, 1, 1, 1, 1, 1, 0), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 1, OP_DATA, 0, 512, 1, 0, 0, 0, 1, 0), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 1, OP_DATA, 1, 512, 1, 0, 0, 0, 0, 0), 1,
			beat(1, K_ERR, 0, 0, E_ACCESS, 0, 1)});
		rows.push_back('{itm(FUNC_REQ, 0, OP_WRQ, 0, 0, 1, 1, 1, 1, 1, 0), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 0, OP_DATA, 1, 1023, 1, 0, 0, 0, 1, 0), 0, rw.res});
		rows.push_back('{itm(FUNC_PKT, 0, OP_DATA, 2, 0, 1, 0, 0, 0, 1, 0), 0, rw.res});
		rows.push_back('{itm(2'd3, 0, OP_RRQ, 0, 0, 1, 1, 1, 1, 1, 0), 0, rw.res});
		rows.push_back('{itm(FUNC_REQ, 0, OP_RRQ, 0, 0, 1, 1, 1, 1, 1, 512), 0, rw.res});
		repeat (6)
			rows.push_back('{itm(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, rw.res});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].it, rows[i].typed, rows[i].res);

		// fill the table, then stall the result side under full tick bursts
		write_reg(CFG_TIMEOUT, 8'd255);
		write_reg(CFG_RETRIES, 8'd15);
		repeat (17)
			send(itm(FUNC_REQ, 0, OP_WRQ, 0, 0, 1, 1, 1, 1, 1, 0), 0, none);
		write_reg(CFG_TIMEOUT, 8'd0);
		hold_req = 1'b1;
		repeat (3)
			send(itm(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		write_reg(CFG_RETRIES, 8'd0);
		send(itm(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_TIMEOUT, 8'd1);
					write_reg(CFG_RETRIES, 8'd0);
				end
				1: begin
					write_reg(CFG_TIMEOUT, 8'd255);
					write_reg(CFG_RETRIES, 8'd15);
				end
				2: begin
					write_reg(CFG_TIMEOUT, 8'($urandom_range(1, 6)));
					write_reg(CFG_RETRIES, 8'($urandom_range(0, 15)));
				end
				default: begin
					write_reg(CFG_TIMEOUT, 8'd5);
					write_reg(CFG_RETRIES, 8'd5);
					no_idle = 1'b1;
				end
			endcase
			repeat (20)
				send(random_item(), 0, none);
		end

		push <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d events (%0d ticks), %0d result beats checked",
			n_items, n_ticks, n_beats);
		$display("timeouts 0 to 255, retries 0 to 15, full table, input stall seen: %0d",
			saw_full);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d beats outstanding", pending_beats.size());
		$display("testbench failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/tftp_pkg.sv
sv/tftp_front.sv
sv/tftp_back.sv
sv/tftp_session_sequencer_unit.sv
dv/testbench.sv
